[design/ack_frame_range_decoder_top_assert.svh]
`ifndef ACK_FRAME_RANGE_DECODER_TOP_ASSERT_SVH
`define ACK_FRAME_RANGE_DECODER_TOP_ASSERT_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define AFRD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("afrd same-cycle check failed");

// Check that cons holds in the cycle after ante holds.
`define AFRD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("afrd next-cycle check failed");

`endif

[design/afrd_pkg.sv]
package afrd_pkg;

  localparam int unsigned PnWidth    = 62;
  localparam int unsigned CountWidth = 16;

  // One frame body byte
  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
    logic       has_ecn;
  } byte_t;

  // One decoded result
  typedef struct packed {
    logic                  range_valid;
    logic [PnWidth-1:0]    range_high;
    logic [PnWidth-1:0]    range_low;
    logic                  is_first_range;
    logic [PnWidth-1:0]    ack_delay;
    logic                  frame_done;
    logic [CountWidth-1:0] consumed_bytes;
    logic                  error_code;
  } result_t;

  // Core output: whether this byte yields a result, and the result itself
  typedef struct packed {
    logic    valid;
    result_t data;
  } core_res_t;

  localparam logic ErrNone      = 1'b0;
  localparam logic ErrUnderflow = 1'b1;

endpackage

[design/afrd_core.sv]
module afrd_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  afrd_pkg::byte_t    item,
  output afrd_pkg::core_res_t res
);
  import afrd_pkg::*;

  typedef enum logic [2:0] {
    PH_LARGEST,
    PH_DELAY,
    PH_COUNT,
    PH_FIRST,
    PH_GAP,
    PH_RANGE,
    PH_ECN,
    PH_DONE
  } phase_t;

  // Parser state
  logic [PnWidth-1:0]    accum;
  logic [2:0]            bytes_left;
  phase_t                phase;
  logic [PnWidth-1:0]    largest;
  logic [PnWidth-1:0]    smallest;
  logic [PnWidth-1:0]    delay_hold;
  logic [PnWidth-1:0]    pend_high;
  logic                  pend_uf;
  logic [PnWidth-1:0]    ranges_left;
  logic [1:0]            ecn_left;
  logic                  ecn_flag;
  logic [CountWidth-1:0] byte_count;
  logic                  uf_flag;

  logic [PnWidth-1:0]    accum_next;
  logic [2:0]            bytes_left_next;
  phase_t                phase_next;
  logic [PnWidth-1:0]    largest_next;
  logic [PnWidth-1:0]    smallest_next;
  logic [PnWidth-1:0]    delay_hold_next;
  logic [PnWidth-1:0]    pend_high_next;
  logic                  pend_uf_next;
  logic [PnWidth-1:0]    ranges_left_next;
  logic [1:0]            ecn_left_next;
  logic                  ecn_flag_next;
  logic [CountWidth-1:0] byte_count_next;
  logic                  uf_flag_next;

  // Frame start view of the control state
  phase_t                e_phase;
  logic [2:0]            e_left;
  logic [CountWidth-1:0] e_count;
  logic                  e_uf;
  logic                  e_ecn;

  logic [PnWidth-1:0]    value;
  logic                  complete;
  logic [PnWidth-1:0]    sub_base;
  logic [PnWidth:0]      low_diff;
  logic [PnWidth+1:0]    gap_diff;
  logic                  have_range;
  logic                  first;
  logic                  done;
  logic                  more_ranges;

  always_comb begin
    e_phase = item.frame_start ? PH_LARGEST : phase;
    e_left  = item.frame_start ? 3'd0 : bytes_left;
    e_count = item.frame_start ? '0 : byte_count;
    e_uf    = item.frame_start ? 1'b0 : uf_flag;
    e_ecn   = item.frame_start ? item.has_ecn : ecn_flag;
  end

  // Assemble the varint: prefix byte sets length, later bytes shift in
  always_comb begin
    if (e_left == 3'd0) begin
      accum_next = {{(PnWidth-6){1'b0}}, item.data_byte[5:0]};
      case (item.data_byte[7:6])
        2'd0:    bytes_left_next = 3'd0;
        2'd1:    bytes_left_next = 3'd1;
        2'd2:    bytes_left_next = 3'd3;
        default: bytes_left_next = 3'd7;
      endcase
    end else begin
      accum_next      = {accum[PnWidth-9:0], item.data_byte};
      bytes_left_next = e_left - 3'd1;
    end
    value    = accum_next;
    complete = (bytes_left_next == 3'd0);
  end

  // Range subtractors; the low-end one is shared by the first and later ranges
  always_comb begin
    sub_base = (e_phase == PH_RANGE) ? pend_high : largest;
    low_diff = {1'b0, sub_base} - {1'b0, value};
    gap_diff = {2'b00, smallest} - {2'b00, value} - {{PnWidth{1'b0}}, 2'd2};
  end

  // Field decode and state advance
  always_comb begin
    phase_next       = e_phase;
    largest_next     = largest;
    smallest_next    = smallest;
    delay_hold_next  = delay_hold;
    pend_high_next   = pend_high;
    pend_uf_next     = pend_uf;
    ranges_left_next = ranges_left;
    ecn_left_next    = item.frame_start ? 2'd0 : ecn_left;
    ecn_flag_next    = e_ecn;
    uf_flag_next     = e_uf;
    byte_count_next  = (e_count == {CountWidth{1'b1}}) ? e_count : e_count + 1'b1;
    have_range       = 1'b0;
    first            = 1'b0;
    done             = 1'b0;
    more_ranges      = 1'b0;

    if (complete) begin
      case (e_phase)
        PH_LARGEST: begin
          largest_next = value;
          phase_next   = PH_DELAY;
        end
        PH_DELAY: begin
          delay_hold_next = value;
          phase_next      = PH_COUNT;
        end
        PH_COUNT: begin
          ranges_left_next = value;
          phase_next       = PH_FIRST;
        end
        PH_FIRST: begin
          if (low_diff[PnWidth]) begin
            uf_flag_next  = 1'b1;
            smallest_next = '0;
          end else begin
            smallest_next = low_diff[PnWidth-1:0];
          end
          have_range  = 1'b1;
          first       = 1'b1;
          more_ranges = (ranges_left != '0);
        end
        PH_GAP: begin
          // Work out the next range's high end now; flag it at range end
          pend_uf_next   = gap_diff[PnWidth+1];
          pend_high_next = gap_diff[PnWidth+1] ? '0 : gap_diff[PnWidth-1:0];
          phase_next     = PH_RANGE;
        end
        PH_RANGE: begin
          largest_next = pend_high;
          if (pend_uf || low_diff[PnWidth]) begin
            uf_flag_next = 1'b1;
          end
          smallest_next    = low_diff[PnWidth] ? '0 : low_diff[PnWidth-1:0];
          ranges_left_next = ranges_left - 1'b1;
          have_range       = 1'b1;
          more_ranges      = (ranges_left != {{(PnWidth-1){1'b0}}, 1'b1});
        end
        PH_ECN: begin
          ecn_left_next = ecn_left - 2'd1;
          if (ecn_left == 2'd1) begin
            phase_next = PH_DONE;
            done       = 1'b1;
          end
        end
        default: begin
          phase_next = PH_DONE;
        end
      endcase

      // Pick what follows a finished range
      if (have_range) begin
        if (more_ranges) begin
          phase_next = PH_GAP;
        end else if (e_ecn) begin
          phase_next    = PH_ECN;
          ecn_left_next = 2'd3;
        end else begin
          phase_next = PH_DONE;
          done       = 1'b1;
        end
      end
    end
  end

  // Hold state; a finished frame ignores bytes until the next frame start
  always_ff @(posedge clk) begin
    if (rst) begin
      accum       <= '0;
      bytes_left  <= '0;
      phase       <= PH_LARGEST;
      largest     <= '0;
      smallest    <= '0;
      delay_hold  <= '0;
      pend_high   <= '0;
      pend_uf     <= 1'b0;
      ranges_left <= '0;
      ecn_left    <= '0;
      ecn_flag    <= 1'b0;
      byte_count  <= '0;
      uf_flag     <= 1'b0;
    end else if (fire && e_phase != PH_DONE) begin
      accum       <= accum_next;
      bytes_left  <= bytes_left_next;
      phase       <= phase_next;
      largest     <= largest_next;
      smallest    <= smallest_next;
      delay_hold  <= delay_hold_next;
      pend_high   <= pend_high_next;
      pend_uf     <= pend_uf_next;
      ranges_left <= ranges_left_next;
      ecn_left    <= ecn_left_next;
      ecn_flag    <= ecn_flag_next;
      byte_count  <= byte_count_next;
      uf_flag     <= uf_flag_next;
    end else if (fire && item.frame_start) begin
      // Frame start on a done parser always leaves the done state above
      phase <= PH_LARGEST;
    end
  end

  // Build the result for this byte
  always_comb begin
    res.valid                 = (e_phase != PH_DONE) && (have_range || done);
    res.data.range_valid      = have_range;
    res.data.range_high       = have_range ? largest_next : '0;
    res.data.range_low        = have_range ? smallest_next : '0;
    res.data.is_first_range   = first;
    res.data.ack_delay        = first ? delay_hold : '0;
    res.data.frame_done       = done;
    res.data.consumed_bytes   = byte_count_next;
    res.data.error_code       = uf_flag_next ? ErrUnderflow : ErrNone;
  end

endmodule

[design/ack_frame_range_decoder_top.sv]
// Channel    Direction  Handshake                   Payload
// bytes      in         byte_valid / byte_stall     byte_item   (afrd_pkg::byte_t)
// results    out        result_valid / result_stall result_item (afrd_pkg::result_t)
//
// One frame body byte is taken every cycle while byte_stall is low; a byte that yields a
// result passes the input register and then the result register. The rate is set by the
// parser state update, a registered loop through varint assembly and range subtractors.
// Reset (rst, synchronous) clears the parser to expect Largest Acknowledged.
// A stalled result holds the output register; one more byte waits in the input register,
// after which byte_stall rises until the result is taken.
module ack_frame_range_decoder_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_stall,
  input  afrd_pkg::byte_t     byte_item,
  output logic                result_valid,
  input  logic                result_stall,
  output afrd_pkg::result_t   result_item
);
  import afrd_pkg::*;

  logic      s1_valid;
  byte_t     s1_item;
  logic      out_free;
  logic      s1_fire;
  core_res_t core_res;

  assign out_free   = !result_valid || !result_stall;
  assign s1_fire    = s1_valid && out_free;
  assign byte_stall = s1_valid && !out_free;

  // Input register: take a request whenever it is empty or the held byte moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!byte_stall) begin
      s1_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      s1_item <= byte_item;
    end
  end

  afrd_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (s1_fire),
    .item (s1_item),
    .res  (core_res)
  );

  // Result register: load when the slot is free or being drained
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= s1_fire && core_res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && core_res.valid) begin
      result_item <= core_res.data;
    end
  end

`include "ack_frame_range_decoder_top_assert.svh"

  `AFRD_ASSERT_SAME(a_stall_only_when_full, byte_stall, result_valid && result_stall)
  `AFRD_ASSERT_NEXT(a_stall_keeps_result, byte_stall, result_valid)
  `AFRD_ASSERT_SAME(a_rangeless_is_done,
                    result_valid && !result_item.range_valid, result_item.frame_done)
  `AFRD_ASSERT_SAME(a_first_has_range,
                    result_valid && result_item.is_first_range, result_item.range_valid)

endmodule
